@@ src/dvru_pkg.sv @@
// -----------------------------------------------------------------------------
// dvru_pkg: shared types and constants for the distance-vector route update
// Word layouts of the request and response channels, command and register
// codes, and reset values of the configuration registers.
// -----------------------------------------------------------------------------
package dvru_pkg;

   localparam int ID_W       = 3;
   localparam int DIST_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam int NODE_COUNT_DEF = 8;

   localparam logic [DIST_W-1:0] DIST_SAT         = '1;
   localparam logic [DIST_W-1:0] MAX_DIST_RST     = DIST_W'(1000);
   localparam logic [ID_W-1:0]   OWN_NODE_RST     = '0;

   // command field codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_VECTOR = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_NODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST = 1'b1;

   typedef struct packed {
      logic              command;
      logic [ID_W-1:0]   sender_id;
      logic [ID_W-1:0]   dest_id;
      logic [DIST_W-1:0] advertised_dist;
      logic              last_element;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   entry_node;
      logic [DIST_W-1:0] entry_dist;
      logic [ID_W-1:0]   entry_hop;
      logic              entry_hop_known;
      logic              entry_changed;
      logic              vector_changed;
      logic              saturated;
   } rsp_type;

endpackage

@@ src/distance_vector_route_update.sv @@
// -----------------------------------------------------------------------------
// distance_vector_route_update: routing table with distance-vector updates
// Holds per-node route distance, next hop and link cost. Load words set a
// link cost and seed the route; vector words relax the route through the
// sender and report the entry after the update.
// -----------------------------------------------------------------------------
//
//   channel   ports                         word       direction
//   request   req_valid/req_ready/req_data  req_type   in
//   response  rsp_valid/rsp_ready/rsp_data  rsp_type   out
//   csr       csr_we/csr_index/csr_wdata    16 bits    in, write only
//
// One word per cycle while the response is not stalled: an input register,
// then one table read, 17-bit add and compare into the response register.
// The table is written in the same cycle the word moves to the response
// register, so the next word sees the update without a bubble.
// Synchronous reset empties both registers and clears the table at once.
// A stalled response holds; the input register keeps taking one more word.
//
module distance_vector_route_update #(
   parameter int NODE_COUNT = dvru_pkg::NODE_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  dvru_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output dvru_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [dvru_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dvru_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // node ids are ID_W bits wide, so entries past 2**ID_W are never reached
   localparam int ID_SPAN     = 1 << dvru_pkg::ID_W;
   localparam int TABLE_DEPTH = (NODE_COUNT < ID_SPAN) ? NODE_COUNT : ID_SPAN;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int DIST_W      = dvru_pkg::DIST_W;
   localparam int ID_W        = dvru_pkg::ID_W;

   logic [DIST_W-1:0] route_dist_ff [TABLE_DEPTH];
   logic [ID_W-1:0]   route_hop_ff  [TABLE_DEPTH];
   logic              route_known_ff[TABLE_DEPTH];
   logic [DIST_W-1:0] link_cost_ff  [TABLE_DEPTH];
   logic              pending_ff, pending_in;

   logic [ID_W-1:0]   own_node_ff;
   logic [DIST_W-1:0] max_dist_ff;

   logic              in_valid_ff;
   dvru_pkg::req_type in_ff;
   logic              out_valid_ff;
   dvru_pkg::rsp_type out_ff;
   dvru_pkg::rsp_type out_in;

   logic advance, fire;

   logic [IDX_W-1:0]  dst_idx, snd_idx;
   logic              dst_in_table, snd_in_table, writable;
   logic [DIST_W-1:0] cost, cur_dist, sum;
   logic [DIST_W:0]   sum_wide;
   logic              sat;
   logic              write_route, write_link, changed;
   logic [DIST_W-1:0] new_dist, new_link;
   logic [ID_W-1:0]   new_hop;
   logic              new_known;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign dst_idx      = in_ff.dest_id[IDX_W-1:0];
   assign snd_idx      = in_ff.sender_id[IDX_W-1:0];
   assign dst_in_table = {1'b0, in_ff.dest_id} < (ID_W+1)'(TABLE_DEPTH);
   assign snd_in_table = {1'b0, in_ff.sender_id} < (ID_W+1)'(TABLE_DEPTH);
   assign writable     = dst_in_table && (in_ff.dest_id != own_node_ff);

   assign cost     = snd_in_table ? link_cost_ff[snd_idx] : '0;
   assign cur_dist = dst_in_table ? route_dist_ff[dst_idx] : '0;
   assign sum_wide = {1'b0, in_ff.advertised_dist} + {1'b0, cost};
   assign sat      = sum_wide[DIST_W];
   assign sum      = sat ? dvru_pkg::DIST_SAT : sum_wide[DIST_W-1:0];

   always_comb begin
      write_route = 1'b0;
      write_link  = 1'b0;
      new_dist    = sum;
      new_hop     = in_ff.sender_id;
      new_known   = 1'b1;
      new_link    = '0;
      if (in_ff.command == dvru_pkg::CMD_LOAD) begin
         write_route = writable;
         write_link  = writable;
         if (in_ff.advertised_dist != '0 && in_ff.advertised_dist < max_dist_ff) begin
            new_dist  = in_ff.advertised_dist;
            new_hop   = in_ff.dest_id;
            new_known = 1'b1;
            new_link  = in_ff.advertised_dist;
         end else begin
            new_dist  = max_dist_ff;
            new_hop   = '0;
            new_known = 1'b0;
         end
      end else begin
         // replace an unreachable route, or a longer one
         write_route = writable &&
                       ((cur_dist == max_dist_ff && in_ff.advertised_dist != max_dist_ff) ||
                        cur_dist > sum);
      end
   end

   assign changed = write_route;

   always_comb begin
      pending_in = pending_ff;
      out_in.entry_node      = in_ff.dest_id;
      out_in.entry_changed   = changed;
      out_in.saturated       = (in_ff.command == dvru_pkg::CMD_VECTOR) && sat;
      out_in.vector_changed  = 1'b0;
      if (in_ff.command == dvru_pkg::CMD_VECTOR) begin
         if (in_ff.last_element) begin
            out_in.vector_changed = pending_ff || changed;
            pending_in            = 1'b0;
         end else begin
            pending_in = pending_ff || changed;
         end
      end
      if (!dst_in_table) begin
         out_in.entry_dist      = '0;
         out_in.entry_hop       = '0;
         out_in.entry_hop_known = 1'b0;
      end else if (write_route) begin
         out_in.entry_dist      = new_dist;
         out_in.entry_hop       = new_hop;
         out_in.entry_hop_known = new_known;
      end else begin
         out_in.entry_dist      = cur_dist;
         out_in.entry_hop       = route_hop_ff[dst_idx];
         out_in.entry_hop_known = route_known_ff[dst_idx];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff <= dvru_pkg::OWN_NODE_RST;
         max_dist_ff <= dvru_pkg::MAX_DIST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            dvru_pkg::CSR_OWN_NODE: own_node_ff <= csr_wdata[ID_W-1:0];
            dvru_pkg::CSR_MAX_DIST: max_dist_ff <= csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // input register and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
            pending_ff   <= pending_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   // route and link tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            route_dist_ff[k]  <= dvru_pkg::DIST_SAT;
            route_hop_ff[k]   <= '0;
            route_known_ff[k] <= 1'b0;
            link_cost_ff[k]   <= '0;
         end
      end else if (fire) begin
         if (write_route) begin
            route_dist_ff[dst_idx]  <= new_dist;
            route_hop_ff[dst_idx]   <= new_hop;
            route_known_ff[dst_idx] <= new_known;
         end
         if (write_link) begin
            link_cost_ff[dst_idx] <= new_link;
         end
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_own_node_fixed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_node == own_node_ff |-> !rsp_data.entry_changed)
      else $error("own node entry reported as changed");

   a_unknown_hop_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_changed && !rsp_data.entry_hop_known
      |-> rsp_data.entry_dist == max_dist_ff)
      else $error("dropped route does not read as unreachable");

   a_sat_vector_only: assert property (@(posedge clock) disable iff (reset)
      fire && in_ff.command == dvru_pkg::CMD_LOAD |=> !rsp_data.saturated)
      else $error("saturation flagged on a load word");

endmodule

@@ dv/tb_distance_vector_route_update.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_distance_vector_route_update: self-checking bench for the route update
// Streams link-cost loads and distance-vector elements under random idling on
// both channels. Each accepted request word is run through a local copy of the
// routing and link tables. Every response word is compared in order against
// the predicted table entry.
// -----------------------------------------------------------------------------
module tb_distance_vector_route_update;

   localparam int NODES  = dvru_pkg::NODE_COUNT_DEF;
   localparam int ID_W   = dvru_pkg::ID_W;
   localparam int DIST_W = dvru_pkg::DIST_W;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   dvru_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   dvru_pkg::rsp_type               rsp_data;
   logic                            csr_we    = 1'b0;
   logic [dvru_pkg::CSR_IDX_W-1:0]  csr_index = dvru_pkg::CSR_OWN_NODE;
   logic [dvru_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // local copy of the routing state and settings
   logic [DIST_W-1:0] dist_tbl [NODES];
   logic [ID_W-1:0]   hop_tbl [NODES];
   logic              hop_known_tbl [NODES];
   logic [DIST_W-1:0] cost_tbl [NODES];
   logic              change_open  = 1'b0;
   logic [ID_W-1:0]   own_node_cfg = dvru_pkg::OWN_NODE_RST;
   logic [DIST_W-1:0] max_dist_cfg = dvru_pkg::MAX_DIST_RST;

   // settings as seen by the stimulus generator
   logic [DIST_W-1:0] gen_max;

   dvru_pkg::req_type outbound_words[$];
   dvru_pkg::rsp_type expected_entries[$];
   logic    req_taken = 1'b0;
   int      send_idle_pct = 14;
   int      recv_idle_pct = 71;
   int      mismatch_count = 0;
   int      n_loads = 0;
   int      n_elements = 0;
   int      n_replaced = 0;
   int      n_saturated = 0;
   int      n_vec_changed = 0;

   distance_vector_route_update #(
      .NODE_COUNT(NODES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Apply one request word to the local tables and return the entry it reports.
   function automatic dvru_pkg::rsp_type relax_route(dvru_pkg::req_type w);
      dvru_pkg::rsp_type entry;
      logic [DIST_W:0]   sum;
      logic [ID_W-1:0]   d;
      logic              writable;
      entry    = '0;
      d        = w.dest_id;
      writable = (d != own_node_cfg);
      if (w.command == dvru_pkg::CMD_LOAD) begin
         if (writable) begin
            if (w.advertised_dist != '0 && w.advertised_dist < max_dist_cfg) begin
               cost_tbl[d]      = w.advertised_dist;
               dist_tbl[d]      = w.advertised_dist;
               hop_tbl[d]       = d;
               hop_known_tbl[d] = 1'b1;
            end else begin
               // not a neighbor: drop the link and mark the route unreachable
               cost_tbl[d]      = '0;
               dist_tbl[d]      = max_dist_cfg;
               hop_tbl[d]       = '0;
               hop_known_tbl[d] = 1'b0;
            end
            entry.entry_changed = 1'b1;
         end
      end else begin
         sum = {1'b0, w.advertised_dist} + {1'b0, cost_tbl[w.sender_id]};
         if (sum[DIST_W]) begin
            sum              = {1'b0, dvru_pkg::DIST_SAT};
            entry.saturated  = 1'b1;
         end
         if (writable && ((dist_tbl[d] == max_dist_cfg && w.advertised_dist != max_dist_cfg)
                          || {1'b0, dist_tbl[d]} > sum)) begin
            dist_tbl[d]         = sum[DIST_W-1:0];
            hop_tbl[d]          = w.sender_id;
            hop_known_tbl[d]    = 1'b1;
            entry.entry_changed = 1'b1;
         end
         change_open = change_open | entry.entry_changed;
         if (w.last_element) begin
            entry.vector_changed = change_open;
            change_open          = 1'b0;
         end
      end
      entry.entry_node      = d;
      entry.entry_dist      = dist_tbl[d];
      entry.entry_hop       = hop_tbl[d];
      entry.entry_hop_known = hop_known_tbl[d];
      return entry;
   endfunction

   function automatic string fmt_entry(dvru_pkg::rsp_type e);
      return $sformatf("node %0d dist %0d hop %0d known %0b changed %0b vector %0b sat %0b",
                       e.entry_node, e.entry_dist, e.entry_hop, e.entry_hop_known,
                       e.entry_changed, e.vector_changed, e.saturated);
   endfunction

   // Monitor: check response words, predict accepted request words, track settings.
   always @(posedge clock) begin
      dvru_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_we) begin
            case (csr_index)
               dvru_pkg::CSR_OWN_NODE: own_node_cfg = csr_wdata[ID_W-1:0];
               dvru_pkg::CSR_MAX_DIST: max_dist_cfg = csr_wdata[DIST_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_entries.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected response word: %s", fmt_entry(rsp_data));
            end else begin
               want = expected_entries.pop_front();
               if (rsp_data !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch at %0t: expected %s", $realtime, fmt_entry(want));
                     $display("                 got      %s", fmt_entry(rsp_data));
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            want = relax_route(req_data);
            expected_entries.push_back(want);
            if (req_data.command == dvru_pkg::CMD_LOAD) n_loads++;
            else n_elements++;
            if (req_data.command == dvru_pkg::CMD_VECTOR && want.entry_changed) n_replaced++;
            if (want.saturated) n_saturated++;
            if (want.vector_changed) n_vec_changed++;
         end
      end
   end

   // Driver: hold the word until taken, then advance or idle.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (outbound_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= outbound_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic push_word(logic cmd, logic [ID_W-1:0] snd, logic [ID_W-1:0] dst,
                            logic [DIST_W-1:0] adv, logic last);
      dvru_pkg::req_type w;
      w.command         = cmd;
      w.sender_id       = snd;
      w.dest_id         = dst;
      w.advertised_dist = adv;
      w.last_element    = last;
      outbound_words.push_back(w);
   endtask

   // Distances clustered around the unreachable value and the 16-bit limits.
   function automatic logic [DIST_W-1:0] pick_dist(logic [DIST_W-1:0] lim);
      case ($urandom_range(9))
         0: return '0;
         1: return DIST_W'(1);
         2: return lim;
         3: return lim - 1'b1;
         4: return lim + 1'b1;
         5: return dvru_pkg::DIST_SAT;
         6: return DIST_W'($urandom_range(1, 40));
         7, 8: return DIST_W'($urandom_range(0, lim));
         default: return DIST_W'($urandom);
      endcase
   endfunction

   task automatic queue_traffic(int count);
      int              made;
      int              len;
      int              kind;
      logic [ID_W-1:0] snd;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(99);
         if (kind < 12) begin
            push_word(1'($urandom), ID_W'($urandom), ID_W'($urandom), DIST_W'($urandom),
                      1'($urandom));
            made++;
         end else if (kind < 32) begin
            len = $urandom_range(1, 3);
            repeat (len) begin
               push_word(dvru_pkg::CMD_LOAD, ID_W'($urandom), ID_W'($urandom),
                         pick_dist(gen_max), 1'($urandom));
               made++;
            end
         end else begin
            len = $urandom_range(1, 6);
            snd = ID_W'($urandom);
            for (int e = 0; e < len; e++) begin
               push_word(dvru_pkg::CMD_VECTOR, snd, ID_W'($urandom), pick_dist(gen_max),
                         e == len - 1);
               made++;
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (outbound_words.size() != 0 || req_valid || expected_entries.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [dvru_pkg::CSR_IDX_W-1:0]  idx,
                            logic [dvru_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic apply_settings(logic [ID_W-1:0] own, logic [DIST_W-1:0] lim);
      wait_drained();
      write_csr(dvru_pkg::CSR_OWN_NODE, {(dvru_pkg::CSR_DATA_W-ID_W)'($urandom), own});
      write_csr(dvru_pkg::CSR_MAX_DIST, lim);
      gen_max = lim;
   endtask

   initial begin
      for (int k = 0; k < NODES; k++) begin
         dist_tbl[k]      = '1;
         hop_tbl[k]       = '0;
         hop_known_tbl[k] = 1'b0;
         cost_tbl[k]      = '0;
      end
      gen_max = dvru_pkg::MAX_DIST_RST;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words on reset settings: own node 0, unreachable at 1000
      push_word(dvru_pkg::CMD_VECTOR, 2, 3, 50, 0); // untouched entry, non-neighbor sender
      push_word(dvru_pkg::CMD_LOAD, 0, 1, 5, 1);    // neighbor load, last flag ignored
      push_word(dvru_pkg::CMD_LOAD, 0, 2, 0, 0);    // zero cost: not a neighbor
      push_word(dvru_pkg::CMD_LOAD, 0, 3, 1000, 0); // cost at unreachable: not a neighbor
      push_word(dvru_pkg::CMD_LOAD, 0, 4, 999, 0);
      push_word(dvru_pkg::CMD_LOAD, 0, 5, 16'hFFFF, 0);
      push_word(dvru_pkg::CMD_LOAD, 0, 0, 7, 0);    // own node stays as it is
      push_word(dvru_pkg::CMD_LOAD, 7, 7, 1, 0);
      push_word(dvru_pkg::CMD_VECTOR, 1, 6, 10, 0);
      push_word(dvru_pkg::CMD_VECTOR, 1, 6, 20, 1); // no change, vector reports earlier one
      push_word(dvru_pkg::CMD_VECTOR, 7, 6, 20, 1); // vector without any change
      push_word(dvru_pkg::CMD_VECTOR, 7, 0, 0, 1);  // own node
      // saturating sum over unreachable route
      push_word(dvru_pkg::CMD_VECTOR, 4, 5, 16'hFFFF, 0);
      // unreachable route takes worse distance
      push_word(dvru_pkg::CMD_VECTOR, 3, 2, 1500, 0);
      // unreachable advertisement is not taken
      push_word(dvru_pkg::CMD_VECTOR, 2, 3, 1000, 1);
      push_word(dvru_pkg::CMD_VECTOR, 5, 4, 0, 1);
      push_word(dvru_pkg::CMD_VECTOR, 4, 7, 16'hFFFE, 0);
      push_word(dvru_pkg::CMD_VECTOR, 7, 1, 3, 1);
      push_word(dvru_pkg::CMD_LOAD, 0, 6, 999, 0);
      push_word(dvru_pkg::CMD_VECTOR, 6, 6, 0, 1);  // equal distance does not replace

      apply_settings(7, 16'hFFFF);
      queue_traffic(110);

      apply_settings(3, 1);
      send_idle_pct = 71;
      recv_idle_pct = 14;
      queue_traffic(70);
      apply_settings(5, 0);                   // zero unreachable value: every load drops link
      queue_traffic(40);

      apply_settings(ID_W'($urandom_range(0, NODES - 1)), DIST_W'($urandom_range(2, 65534)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_traffic(75);
      wait_drained();
      queue_traffic(75);
      apply_settings(0, 1000);
      queue_traffic(160);

      wait_drained();
      $display("Ran %0d link loads and %0d vector elements over six register settings.",
               n_loads, n_elements);
      $display("Saw %0d route replacements, %0d saturated sums, %0d changed vectors.",
               n_replaced, n_saturated, n_vec_changed);
      if (mismatch_count == 0 && expected_entries.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("Timeout: %0d response words still outstanding", expected_entries.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
